@@ sv/assert_macros.svh @@
// assertion helpers shared by the checker files
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define CHR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chr assertion failed");

// next-cycle implication under an active-low reset
`define CHR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chr assertion failed");

`endif

@@ sv/chr_pkg.sv @@
// shared types and codes for the hash ring block
// no dependencies; used by the core, the probe and the checker
package chr_pkg;

    localparam int HASH_W  = 32;
    localparam int NODE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int ENTS_W  = 11;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] node_number;
        logic [HASH_W-1:0] hash_value;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] owner_node;
        logic [STAT_W-1:0] status;
        logic [ENTS_W-1:0] ring_entries;
    } rsp_t;

    // one ring position as held in memory
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [NODE_W-1:0] owner;
    } entry_t;

endpackage

@@ sv/consistent_hash_ring_core.sv @@
// Sorted hash ring with insert, remove-node and lookup operations.
//
// Request channel (req_valid/req_ready/req) takes one word per operation:
// mode, node_number, hash_value. Response channel (rsp_valid/rsp_ready/rsp)
// returns exactly one word per request: owner_node, status, ring_entries.
// The block handles one request at a time; req_ready is high only while
// the sequencer is idle, and a finished response sits in an output
// register so the next request can be taken while it waits.
// Every probe of the ring is a registered read of one memory port, with
// log2(entries)+1 binary search steps at most. Lookup is a search and a
// read of the entry found; insert is a search, then a read and a write per
// entry moved behind the new position; remove reads every entry held and
// writes back those it keeps. Insert into a full ring, lookup on an empty
// ring and mode three go straight to the response. The next request can be
// taken in the cycle after each response is registered. Reset clears the
// state, the entry count and the response valid flag only; memory contents
// are never read before being written, so no clearing pass is needed.
// If the receiver stalls, the response is held and the block finishes at
// most one more request, then waits with req_ready low.
// Depends on chr_pkg, chr_ram and chr_probe.
module consistent_hash_ring_core
    import chr_pkg::*;
#(
    parameter int RING_DEPTH = 1024
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SRCH_ADDR = 4'd1;
    localparam logic [3:0] S_SRCH_CMP  = 4'd2;
    localparam logic [3:0] S_INS_RD    = 4'd3;
    localparam logic [3:0] S_INS_WR    = 4'd4;
    localparam logic [3:0] S_REM_RD    = 4'd5;
    localparam logic [3:0] S_REM_CHK   = 4'd6;
    localparam logic [3:0] S_LK_RD     = 4'd7;
    localparam logic [3:0] S_LK_DATA   = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0]        state_reg, state_next;
    req_t              op_reg, op_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [NODE_W-1:0] owner_reg, owner_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    entry_t            ram_rdata;

    logic              srch_active;
    logic [AW-1:0]     srch_mid;
    logic [CW-1:0]     srch_lo_step;
    logic [CW-1:0]     srch_hi_step;
    logic [CW-1:0]     idx_dec;

    // ring storage
    chr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared search step unit
    chr_probe #(
        .AW (AW),
        .CW (CW)
    ) u_probe (
        .lo         (lo_reg),
        .hi         (hi_reg),
        .key        (op_reg.hash_value),
        .probe_hash (ram_rdata.hash),
        .upper      (op_reg.mode == MODE_INSERT),
        .active     (srch_active),
        .mid        (srch_mid),
        .lo_step    (srch_lo_step),
        .hi_step    (srch_hi_step)
    );

    assign idx_dec   = idx_reg - CW'(1);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        owner_next     = owner_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = srch_mid;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req;
                    owner_next  = '0;
                    status_next = ST_OK;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    idx_next    = '0;
                    case (req.mode)
                        MODE_INSERT:
                        begin
                            if (count_reg >= DEPTH_C)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SRCH_ADDR;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            state_next = S_REM_RD;
                        end
                        MODE_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SRCH_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // issue a probe read, or leave once the window is closed
            S_SRCH_ADDR:
            begin
                if (srch_active)
                begin
                    state_next = S_SRCH_CMP;
                end
                else if (op_reg.mode == MODE_INSERT)
                begin
                    idx_next   = count_reg;
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_LK_RD;
                end
            end

            S_SRCH_CMP:
            begin
                lo_next    = srch_lo_step;
                hi_next    = srch_hi_step;
                state_next = S_SRCH_ADDR;
            end

            // move entries up one slot from the top down to the new position
            S_INS_RD:
            begin
                if (idx_reg > lo_reg)
                begin
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = S_INS_WR;
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = lo_reg[AW-1:0];
                    ram_wdata.hash  = op_reg.hash_value;
                    ram_wdata.owner = op_reg.node_number;
                    count_next      = count_reg + CW'(1);
                    state_next      = S_DONE;
                end
            end

            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = S_INS_RD;
            end

            // compaction sweep: idx reads, lo writes
            S_REM_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_REM_CHK;
                end
                else
                begin
                    count_next = lo_reg;
                    state_next = S_DONE;
                end
            end

            S_REM_CHK:
            begin
                if (ram_rdata.owner != op_reg.node_number)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = lo_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    lo_next   = lo_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_REM_RD;
            end

            // wrap to the first position when the key is above every hash
            S_LK_RD:
            begin
                ram_raddr  = (lo_reg >= count_reg) ? '0 : lo_reg[AW-1:0];
                state_next = S_LK_DATA;
            end

            S_LK_DATA:
            begin
                owner_next = ram_rdata.owner;
                state_next = S_DONE;
            end

            // hand the word to the output register once it is free
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.owner_node   = owner_reg;
                    rsp_next.status       = status_reg;
                    rsp_next.ring_entries = ENTS_W'(count_reg);
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        owner_reg  <= owner_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

endmodule

@@ sv/chr_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module chr_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/chr_probe.sv @@
// one binary search step: midpoint, hash compare and bound update
// depends on chr_pkg for the hash width
module chr_probe
    import chr_pkg::*;
#(
    parameter int AW = 10,
    parameter int CW = 11
)(
    input  logic [CW-1:0]     lo,
    input  logic [CW-1:0]     hi,
    input  logic [HASH_W-1:0] key,
    input  logic [HASH_W-1:0] probe_hash,
    input  logic              upper,
    output logic              active,
    output logic [AW-1:0]     mid,
    output logic [CW-1:0]     lo_step,
    output logic [CW-1:0]     hi_step
);

    logic [CW-1:0] span;
    logic [CW-1:0] mid_full;
    logic          go_right;

    // midpoint of the open window
    assign span     = hi - lo;
    assign mid_full = lo + (span >> 1);
    assign mid      = mid_full[AW-1:0];
    assign active   = (lo < hi);

    // upper bound skips equal hashes, lower bound stops on them
    assign go_right = upper ? (probe_hash <= key) : (probe_hash < key);
    assign lo_step  = go_right ? (mid_full + CW'(1)) : lo;
    assign hi_step  = go_right ? hi : mid_full;

endmodule

@@ sv/chr_checker.sv @@
// port-level checks for the hash ring core, bound to the top level
// depends on chr_pkg and assert_macros.svh
`include "assert_macros.svh"

module chr_checker
    import chr_pkg::*;
#(
    parameter int RING_DEPTH = 1024
)(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // one request at a time: busy right after taking a word
    `CHR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)

    // an empty ring reports no entries and no owner
    `CHR_ASSERT_IMPL(a_empty_consistent, clk, rst_n, rsp_valid && (rsp.status == ST_EMPTY), (rsp.ring_entries == '0) && (rsp.owner_node == '0))

    // a full ring reports the whole depth and no owner
    `CHR_ASSERT_IMPL(a_full_consistent, clk, rst_n, rsp_valid && (rsp.status == ST_FULL), (rsp.ring_entries == ENTS_W'(RING_DEPTH)) && (rsp.owner_node == '0))

    // a stalled response word holds
    `CHR_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind consistent_hash_ring_core chr_checker #(.RING_DEPTH(RING_DEPTH)) u_chr_checker (.*);
